### sv/ubt_pkg.sv
// Shared types and codes for the unordered bag table.
// No dependencies; every other file refers to it by scoped names.
package ubt_pkg;

  localparam int unsigned FIELD_W = 5;

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_COUNT  = 2'd2;
  localparam logic [1:0] ACT_CLEAR  = 2'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic               ok;
    logic [FIELD_W-1:0] match_count;
    logic [FIELD_W-1:0] size_now;
    logic               is_empty;
  } out_item_t;

  // Decoded operation, exactly one bit set per queued item.
  typedef struct packed {
    logic add;
    logic remove;
    logic count;
    logic clear;
  } op_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] value;
  } cmd_t;

endpackage

### sv/unordered_bag_table_top.sv
// Top level of the unordered bag table: a front end with a small command
// queue feeding a back end that owns the entry memory. Uses ubt_pkg.
//
// Unordered multiset of up to CAPACITY signed 32-bit values. Each item is an
// action (add, remove one, count, clear) with a value, and each item gives
// exactly one result: ok flag, number of live entries equal to the value
// (zero for add and clear), size after the action and an empty flag; counts
// wider than 5 bits wrap. Add and clear go straight from the idle state to the
// response state in the back end. Count and remove scan all live entries,
// because the back end reads the entry memory through its single registered
// read port one entry per cycle; a remove that finds the value then reads the
// last entry and writes it into the freed slot. While the output register
// stays stalled, the back end waits in its response state. The front queue
// holds two items, so input is taken while the back end scans, and the
// output register holds a finished result while the next item is worked on.
module unordered_bag_table_top #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ubt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ubt_pkg::out_item_t out_data
);

  // Decoded commands waiting for the back end.
  logic          q_valid;
  logic          q_take;
  ubt_pkg::cmd_t q_cmd;

  ubt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_take   (q_take),
    .q_cmd    (q_cmd)
  );

  // Execute one command at a time; results leave through a holding register.
  ubt_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_take    (q_take),
    .q_cmd     (q_cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### sv/ubt_front.sv
// Front end of the unordered bag table: accepts items, decodes the action
// and holds them in a two-entry queue for the back end. Uses ubt_pkg.
module ubt_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ubt_pkg::in_item_t in_data,
  output logic              q_valid,
  input  logic              q_take,
  output ubt_pkg::cmd_t     q_cmd
);

  ubt_pkg::cmd_t slot_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  ubt_pkg::cmd_t dec_cmd;
  logic          push, pop;

  always_comb begin
    dec_cmd.value = in_data.item_value;
    dec_cmd.op    = '0;
    case (in_data.action)
      ubt_pkg::ACT_ADD:    dec_cmd.op.add    = 1'b1;
      ubt_pkg::ACT_REMOVE: dec_cmd.op.remove = 1'b1;
      ubt_pkg::ACT_COUNT:  dec_cmd.op.count  = 1'b1;
      default:             dec_cmd.op.clear  = 1'b1;
    endcase
  end

  assign in_stall = (cnt_r == 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = slot_r[rd_ptr_r];
  assign push     = in_valid && !in_stall;
  assign pop      = q_take && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= dec_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### sv/ubt_back.sv
// Back end of the unordered bag table: entry memory, scan sequencer and
// output register. Uses ubt_pkg; fed by ubt_front.
module ubt_back #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_take,
  input  ubt_pkg::cmd_t      q_cmd,
  output logic               out_valid,
  input  logic               out_stall,
  output ubt_pkg::out_item_t out_data
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_SCAN    = 5'b00010,
    ST_MOVE_RD = 5'b00100,
    ST_MOVE_WR = 5'b01000,
    ST_RESP    = 5'b10000
  } state_t;

  logic [31:0] mem [CAPACITY];

  state_t             state_r, state_nxt;
  ubt_pkg::op_t       op_r, op_nxt;
  logic [31:0]        val_r, val_nxt;
  logic [CW-1:0]      total_r, total_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]      match_r, match_nxt;
  logic [AW-1:0]      slot_r, slot_nxt;
  logic [AW-1:0]      pend_idx_r, pend_idx_nxt;
  logic               pend_r, pend_nxt;
  logic               found_r, found_nxt;
  logic               ok_r, ok_nxt;
  logic               out_valid_r, out_valid_nxt;
  ubt_pkg::out_item_t out_data_r, out_data_nxt;

  logic [AW-1:0] rd_addr;
  logic [31:0]   rd_data_r;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic          issue;
  logic          hit;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    val_nxt       = val_r;
    total_nxt     = total_r;
    idx_nxt       = idx_r;
    match_nxt     = match_r;
    slot_nxt      = slot_r;
    pend_idx_nxt  = pend_idx_r;
    pend_nxt      = 1'b0;
    found_nxt     = found_r;
    ok_nxt        = ok_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    q_take        = 1'b0;
    rd_addr       = idx_r[AW-1:0];
    wr_en         = 1'b0;
    wr_addr       = total_r[AW-1:0];
    wr_data       = val_r;
    issue         = 1'b0;
    hit           = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_take    = 1'b1;
          op_nxt    = q_cmd.op;
          val_nxt   = q_cmd.value;
          match_nxt = '0;
          idx_nxt   = '0;
          found_nxt = 1'b0;
          ok_nxt    = 1'b0;
          state_nxt = ST_RESP;
          if (q_cmd.op.add) begin
            if (total_r < CAP_C) begin
              wr_en     = 1'b1;
              wr_data   = q_cmd.value;
              total_nxt = total_r + CW'(1);
              ok_nxt    = 1'b1;
            end
          end else if (q_cmd.op.clear) begin
            total_nxt = '0;
            ok_nxt    = 1'b1;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // Read one entry a cycle; compare the entry read the cycle before.
        issue = (idx_r < total_r);
        if (issue) begin
          idx_nxt      = idx_r + CW'(1);
          pend_nxt     = 1'b1;
          pend_idx_nxt = idx_r[AW-1:0];
        end
        hit = pend_r && (rd_data_r == val_r);
        if (hit) begin
          match_nxt = match_r + CW'(1);
          if (!found_r) begin
            found_nxt = 1'b1;
            slot_nxt  = pend_idx_r;
          end
        end
        if (!issue && !pend_r) begin
          if (op_r.remove && found_r) begin
            total_nxt = total_r - CW'(1);
            ok_nxt    = 1'b1;
            state_nxt = ST_MOVE_RD;
          end else begin
            ok_nxt    = op_r.count && (match_r != '0);
            state_nxt = ST_RESP;
          end
        end
      end
      ST_MOVE_RD: begin
        // Fetch the last live entry to refill the freed slot.
        rd_addr   = total_r[AW-1:0];
        state_nxt = ST_MOVE_WR;
      end
      ST_MOVE_WR: begin
        wr_en     = 1'b1;
        wr_addr   = slot_r;
        wr_data   = rd_data_r;
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.ok          = ok_r;
          out_data_nxt.match_count = ubt_pkg::FIELD_W'(match_r);
          out_data_nxt.size_now    = ubt_pkg::FIELD_W'(total_r);
          out_data_nxt.is_empty    = (total_r == '0);
          state_nxt                = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    val_r      <= val_nxt;
    idx_r      <= idx_nxt;
    match_r    <= match_nxt;
    slot_r     <= slot_nxt;
    pend_idx_r <= pend_idx_nxt;
    found_r    <= found_nxt;
    ok_r       <= ok_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      total_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
